@@ src/ssid_pkg.sv @@
// ----------------------------------------------------------------------------
// ssid_pkg: shared types for the sorted set core
// Status codes, action codes and the cell link/control structs.
// ----------------------------------------------------------------------------
package ssid_pkg;

  localparam int ValW    = 32;
  localparam int StatusW = 3;
  localparam int CountW  = 6;

  // Action codes on the input channel
  localparam logic ActInsert = 1'b0;
  localparam logic ActDump   = 1'b1;

  // Result status codes
  localparam logic [StatusW-1:0] StInserted = 3'd0;
  localparam logic [StatusW-1:0] StDup      = 3'd1;
  localparam logic [StatusW-1:0] StFull     = 3'd2;
  localparam logic [StatusW-1:0] StEntry    = 3'd3;
  localparam logic [StatusW-1:0] StEmpty    = 3'd4;

  // What one cell shows its neighbors
  typedef struct packed {
    logic signed [ValW-1:0] val;
    logic                   valid;
    logic                   lt;     // holds a value below the incoming one
    logic                   eq;     // holds a value equal to the incoming one
  } link_t;

  // Per-cycle command broadcast along the chain
  typedef struct packed {
    logic ins;  // place the incoming value
    logic rot;  // rotate held entries one place toward the head
  } ctl_t;

endpackage

@@ src/sorted_set_insert_dedup_core.sv @@
// ----------------------------------------------------------------------------
// sorted_set_insert_dedup_core: bounded ascending set of signed 32-bit values
// Inserts with duplicate drop, full flag, and ascending read out.
// ----------------------------------------------------------------------------
//
//  channel | ports                                  | direction
//  --------+----------------------------------------+----------
//  in      | in_valid in_ready in_action in_value    | sink
//  out     | out_valid out_ready out_status          | source
//          | out_entry out_count out_last            |
//
//  On an insert beat every cell compares against the value in parallel, the
//  chain shifts at the accept edge, and the status lands in the output
//  register. A dump beat streams count entries, one per cycle,
//  by rotating the chain toward cell 0; input is held off until the last
//  entry is loaded. Output stalls back-pressure the chain (no rotation
//  while the output register is full). Reset is synchronous and empties
//  the set at once through the cell valid bits.
// ----------------------------------------------------------------------------
module sorted_set_insert_dedup_core #(
  parameter int CAPACITY = 32
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 in_action,
  input  logic signed [ssid_pkg::ValW-1:0]     in_value,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [ssid_pkg::StatusW-1:0]         out_status,
  output logic signed [ssid_pkg::ValW-1:0]     out_entry,
  output logic [ssid_pkg::CountW-1:0]          out_count,
  output logic                                 out_last
);

  localparam int CW = $clog2(CAPACITY + 1);

  typedef enum logic {S_IDLE, S_DUMP} state_t;

  state_t                                state_r;
  logic [CW-1:0]                         count_r;
  logic [CW-1:0]                         remain_r;
  logic                                  out_valid_r;
  logic [ssid_pkg::StatusW-1:0]          out_status_r;
  logic signed [ssid_pkg::ValW-1:0]      out_entry_r;
  logic [ssid_pkg::CountW-1:0]           out_count_r;
  logic                                  out_last_r;

  ssid_pkg::link_t                       links [CAPACITY];
  logic [CAPACITY-1:0]                   eq_vec;
  ssid_pkg::ctl_t                        ctl;

  logic                                  load, in_acc, dup, full;
  logic                                  ins_go, dump_first, dump_more;
  logic [CW-1:0]                         count_nxt;

  // --------------------------------------------------------------------------
  // Handshake and control decode
  // --------------------------------------------------------------------------
  assign load       = !out_valid_r || out_ready;
  assign in_ready   = (state_r == S_IDLE) && load;
  assign in_acc     = in_valid && in_ready;
  assign dup        = |eq_vec;
  assign full       = (count_r == CW'(CAPACITY));
  assign ins_go     = in_acc && (in_action == ssid_pkg::ActInsert) && !dup && !full;
  assign dump_first = in_acc && (in_action == ssid_pkg::ActDump) && (count_r != '0);
  assign dump_more  = (state_r == S_DUMP) && load;
  assign count_nxt  = ins_go ? count_r + CW'(1) : count_r;

  assign ctl.ins = ins_go;
  assign ctl.rot = dump_first || dump_more;

  // --------------------------------------------------------------------------
  // Cell chain: cell 0 holds the smallest value
  // --------------------------------------------------------------------------
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    ssid_pkg::link_t left_l, right_l;

    if (i == 0) begin : g_head
      // nothing below the head: it is the insertion point unless it is smaller
      assign left_l = '{val: '0, valid: 1'b0, lt: 1'b1, eq: 1'b0};
    end else begin : g_mid
      assign left_l = links[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_l = '{val: '0, valid: 1'b0, lt: 1'b0, eq: 1'b0};
    end else begin : g_body
      assign right_l = links[i+1];
    end

    ssid_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl),
      .new_val  (in_value),
      .head_val (links[0].val),
      .left     (left_l),
      .right    (right_l),
      .self     (links[i])
    );

    assign eq_vec[i] = links[i].eq;
  end

  // --------------------------------------------------------------------------
  // Sequencer and output register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      remain_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            out_valid_r <= 1'b1;
            out_count_r <= ssid_pkg::CountW'(count_nxt);
            out_entry_r <= '0;
            out_last_r  <= 1'b1;
            if (in_action == ssid_pkg::ActInsert) begin
              if (dup) begin
                out_status_r <= ssid_pkg::StDup;
              end else if (full) begin
                out_status_r <= ssid_pkg::StFull;
              end else begin
                out_status_r <= ssid_pkg::StInserted;
              end
            end else if (dump_first) begin
              // first entry straight from the head cell
              out_status_r <= ssid_pkg::StEntry;
              out_entry_r  <= links[0].val;
              out_last_r   <= (count_r == CW'(1));
              remain_r     <= count_r - CW'(1);
              if (count_r != CW'(1)) begin
                state_r <= S_DUMP;
              end
            end else begin
              out_status_r <= ssid_pkg::StEmpty;
            end
          end
        end
        S_DUMP: begin
          if (dump_more) begin
            out_valid_r  <= 1'b1;
            out_status_r <= ssid_pkg::StEntry;
            out_entry_r  <= links[0].val;
            out_count_r  <= ssid_pkg::CountW'(count_r);
            out_last_r   <= (remain_r == CW'(1));
            remain_r     <= remain_r - CW'(1);
            if (remain_r == CW'(1)) begin
              state_r <= S_IDLE;
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_entry  = out_entry_r;
  assign out_count  = out_count_r;
  assign out_last   = out_last_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("held count above capacity");

  a_head_valid: assert property (@(posedge clk) disable iff (!rst_n)
    links[0].valid == (count_r != '0))
    else $error("head cell valid bit disagrees with held count");

  a_dump_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DUMP) |-> (!in_ready && remain_r != '0))
    else $error("input open or nothing left during read out");

  a_dump_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (dump_more && remain_r == CW'(1)) |=> (state_r == S_IDLE && out_last))
    else $error("read out did not close on its last entry");

endmodule

@@ src/ssid_cell.sv @@
// ----------------------------------------------------------------------------
// ssid_cell: one slot of the sorted chain
// Compares against the incoming value, shifts right on insert, rotates on dump.
// ----------------------------------------------------------------------------
module ssid_cell (
  input  logic                                clk,
  input  logic                                rst_n,
  input  ssid_pkg::ctl_t                      ctl,
  input  logic signed [ssid_pkg::ValW-1:0]    new_val,
  input  logic signed [ssid_pkg::ValW-1:0]    head_val,
  input  ssid_pkg::link_t                     left,
  input  ssid_pkg::link_t                     right,
  output ssid_pkg::link_t                     self
);

  logic signed [ssid_pkg::ValW-1:0] val_r, val_nxt;
  logic                             valid_r, valid_nxt;
  logic                             lt, eq, tail;

  assign lt   = valid_r && (val_r < new_val);
  assign eq   = valid_r && (val_r == new_val);
  assign tail = valid_r && !right.valid;

  always_comb begin
    val_nxt   = val_r;
    valid_nxt = valid_r;
    if (ctl.ins) begin
      if (!lt && left.lt) begin
        // insertion point
        val_nxt   = new_val;
        valid_nxt = 1'b1;
      end else if (!lt) begin
        // above the insertion point: shift up by one
        val_nxt   = left.val;
        valid_nxt = left.valid;
      end
    end else if (ctl.rot && valid_r) begin
      val_nxt = tail ? head_val : right.val;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign self = '{val: val_r, valid: valid_r, lt: lt, eq: eq};

endmodule
